### rtl/core/p2c_pkg.sv
package p2c_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int STAGE_W       = $clog2(ATAN_ENTRIES);

	localparam int RAD_W   = 16;
	localparam int ANG_W   = 24;
	localparam int COORD_W = 18;
	localparam int XY_W    = 34;              // Q10.24 plus CORDIC growth
	localparam int Z_W     = 32;              // binary angle, full circle = 2^32
	localparam int K_W     = 31;
	localparam int PROD_W  = XY_W + K_W;
	localparam int XR_W    = COORD_W + 1;
	localparam int XR_LSB  = 46;

	// angle reduction: u = ang + 92 full turns is never negative, and
	// z = floor(u * 2^21 / 45) mod 2^32 = {q[10:0], floor(rem * 2^21 / 45)}
	localparam int ANGLE_DIV = 45;
	localparam int U_W       = 25;
	localparam int QU_W      = 11;
	localparam int REM_W     = 6;
	localparam int FRAC_W    = 21;
	localparam int RECIP_W   = 26;
	localparam int RECIP_SH  = 31;
	localparam int MULT_W    = U_W + RECIP_W;
	localparam logic signed [U_W:0]       ANG_OFFSET = 26'sd8478720;
	localparam logic [RECIP_W-1:0]        RECIP_DIV  = 26'd47721859;
	localparam logic [REM_W-1:0]          DIV_NARROW = REM_W'(ANGLE_DIV);

	localparam logic signed [Z_W-1:0] Z_QUARTER_POS = 32'sd1073741824;
	localparam logic signed [Z_W-1:0] Z_QUARTER_NEG = -32'sd1073741824;

	localparam logic signed [K_W-1:0]    GAIN_K     = 31'sd652032874;
	localparam logic signed [PROD_W-1:0] GAIN_ROUND = 65'sd35184372088832;

	localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81
	};

	typedef logic [ANGLE_DIV-1:0][FRAC_W-1:0] frac_tab_t;

	function automatic frac_tab_t build_frac_tab();
		frac_tab_t t;
		for (int i = 0; i < ANGLE_DIV; i++) begin
			t[i] = FRAC_W'((i << FRAC_W) / ANGLE_DIV);
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

	localparam logic [1:0] REG_X_LOW  = 2'd0;
	localparam logic [1:0] REG_X_HIGH = 2'd1;
	localparam logic [1:0] REG_Y_LOW  = 2'd2;
	localparam logic [1:0] REG_Y_HIGH = 2'd3;

	typedef struct packed {
		logic                   flip;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_lo;
		logic signed [COORD_W-1:0] x_hi;
		logic signed [COORD_W-1:0] y_lo;
		logic signed [COORD_W-1:0] y_hi;
	} limits_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_out;
		logic [COORD_W-1:0] y_out;
		logic               x_rep;
		logic               y_rep;
	} result_t;

endpackage

### rtl/core/p2c_angle.sv
module p2c_angle
	import p2c_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [RAD_W-1:0] radius,
	input  logic signed [ANG_W-1:0] angle,
	output logic                    out_valid,
	output cordic_t                 out_data
);

	logic signed [U_W:0]     u_wide;
	logic [U_W-1:0]          u;
	logic [MULT_W-1:0]       prod;
	logic                    valid_s1;
	logic [QU_W-1:0]         qu_s1;
	logic [REM_W-1:0]        ulo_s1;
	logic signed [RAD_W-1:0] rad_s1;
	logic [2*REM_W-1:0]      qmul;
	logic [REM_W-1:0]        rem;
	logic signed [Z_W-1:0]   z_raw;
	logic                    flip;
	logic                    valid_s2;
	cordic_t                 data_s2;

	assign u_wide = (U_W+1)'(angle) + ANG_OFFSET;
	assign u      = u_wide[U_W-1:0];
	assign prod   = MULT_W'(u) * MULT_W'(RECIP_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qu_s1  <= prod[RECIP_SH +: QU_W];
			ulo_s1 <= u[REM_W-1:0];
			rad_s1 <= radius;
		end
	end

	// remainder only needs the low bits, it is known to be below the divisor
	assign qmul  = DIV_NARROW * qu_s1[REM_W-1:0];
	assign rem   = ulo_s1 - qmul[REM_W-1:0];
	assign z_raw = {qu_s1, FRAC_TAB[rem]};
	assign flip  = (z_raw > Z_QUARTER_POS) || (z_raw < Z_QUARTER_NEG);

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2.flip <= flip;
			data_s2.x    <= XY_W'(rad_s1) <<< 16;
			data_s2.y    <= '0;
			// moving by half a turn toggles the top bit
			data_s2.z    <= {z_raw[Z_W-1] ^ flip, z_raw[Z_W-2:0]};
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

### rtl/core/p2c_cell.sv
module p2c_cell
	import p2c_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [STAGE_W-1:0] stage,
	input  logic               in_valid,
	input  cordic_t            in_data,
	output logic               out_valid,
	output cordic_t            out_data
);

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0]  atan;
	logic                   valid_q;
	cordic_t                data_q;

	assign dx   = in_data.y >>> stage;
	assign dy   = in_data.x >>> stage;
	assign atan = ATAN_TAB[stage];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.flip <= in_data.flip;
			if (!in_data.z[Z_W-1]) begin
				data_q.x <= in_data.x - dx;
				data_q.y <= in_data.y + dy;
				data_q.z <= in_data.z - atan;
			end else begin
				data_q.x <= in_data.x + dx;
				data_q.y <= in_data.y - dy;
				data_q.z <= in_data.z + atan;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### rtl/core/p2c_gain.sv
module p2c_gain
	import p2c_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  limits_t limits,
	input  logic    in_valid,
	input  cordic_t in_data,
	output logic    out_valid,
	output result_t out_data
);

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [XY_W-1:0]   xn_s1, yn_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic signed [PROD_W-1:0] sx, sy;
	logic signed [XR_W-1:0]   xr, yr;
	logic signed [XR_W-1:0]   x_lo, x_hi, y_lo, y_hi;
	logic                     x_bad, y_bad;
	result_t                  res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s1 <= in_data.flip ? -in_data.x : in_data.x;
			yn_s1 <= in_data.flip ? -in_data.y : in_data.y;
			px_s2 <= PROD_W'(xn_s1) * PROD_W'(GAIN_K);
			py_s2 <= PROD_W'(yn_s1) * PROD_W'(GAIN_K);
		end
	end

	// round to nearest, ties up, down to Q10.8
	assign sx = px_s2 + GAIN_ROUND;
	assign sy = py_s2 + GAIN_ROUND;
	assign xr = sx[XR_LSB +: XR_W];
	assign yr = sy[XR_LSB +: XR_W];

	assign x_lo  = XR_W'(limits.x_lo);
	assign x_hi  = XR_W'(limits.x_hi);
	assign y_lo  = XR_W'(limits.y_lo);
	assign y_hi  = XR_W'(limits.y_hi);
	assign x_bad = (xr > x_hi) || (xr < x_lo);
	assign y_bad = (yr > y_hi) || (yr < y_lo);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.x_out <= x_bad ? limits.x_lo : xr[COORD_W-1:0];
			res_s3.y_out <= y_bad ? limits.y_lo : yr[COORD_W-1:0];
			res_s3.x_rep <= x_bad;
			res_s3.y_rep <= y_bad;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = res_s3;

endmodule

### rtl/core/polar_to_cartesian_clamped.sv
// Polar to rectangular converter with per-coordinate acceptance windows.
// Input stream s_*: s_tdata[15:0] radius (signed Q8.8), s_tdata[39:16]
// angle in degrees (signed Q16.8, any value, reduced modulo 360).
// Output stream m_*: m_tdata[17:0] x, m_tdata[35:18] y (signed Q10.8),
// m_tuser[0] x replaced, m_tuser[1] y replaced. A coordinate outside its
// window [low, high] is replaced by the low limit and its flag set.
// Config: cfg_we writes cfg_data into the limit picked by cfg_index
// (0 x low, 1 x high, 2 y low, 3 y high); write only while idle.
// Throughput: one item per cycle while the output is not stalled, fully
// pipelined: angle reduction (2 stages), a chain of CORDIC_STAGES rotation
// cells, then negate, gain multiply and round/window (3 stages), then the
// output register.
// Reset: pipeline and output empty, limits at full range.
// Stall: a skid register catches one more item while m_tready is low; once
// it is full s_tready drops and the whole pipeline holds.
module polar_to_cartesian_clamped
	import p2c_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,   // radius_in[15:0], angle_degrees[39:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // x_out[17:0], y_out[35:18], zero[39:36]
	output logic [1:0]           m_tuser,   // x_replaced[0], y_replaced[1]
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	limits_t limits_q;
	logic    en;
	logic    chain_valid [CORDIC_STAGES+1];
	cordic_t chain_data  [CORDIC_STAGES+1];
	logic    pipe_valid;
	result_t pipe_data;
	logic    push;
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.x_lo <= {1'b1, {(COORD_W-1){1'b0}}};
			limits_q.x_hi <= {1'b0, {(COORD_W-1){1'b1}}};
			limits_q.y_lo <= {1'b1, {(COORD_W-1){1'b0}}};
			limits_q.y_hi <= {1'b0, {(COORD_W-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_LOW:  limits_q.x_lo <= cfg_data;
				REG_X_HIGH: limits_q.x_hi <= cfg_data;
				REG_Y_LOW:  limits_q.y_lo <= cfg_data;
				REG_Y_HIGH: limits_q.y_hi <= cfg_data;
			endcase
		end
	end

	assign en       = !skid_valid_q;
	assign s_tready = en;

	p2c_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.radius    (s_tdata[RAD_W-1:0]),
		.angle     (s_tdata[RAD_W +: ANG_W]),
		.out_valid (chain_valid[0]),
		.out_data  (chain_data[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		p2c_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.stage     (STAGE_W'(g)),
			.in_valid  (chain_valid[g]),
			.in_data   (chain_data[g]),
			.out_valid (chain_valid[g+1]),
			.out_data  (chain_data[g+1])
		);
	end

	p2c_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.limits    (limits_q),
		.in_valid  (chain_valid[CORDIC_STAGES]),
		.in_data   (chain_data[CORDIC_STAGES]),
		.out_valid (pipe_valid),
		.out_data  (pipe_data)
	);

	// the last pipeline stage hands its item on whenever the pipeline moves
	assign push = en && pipe_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : pipe_data;
		end else if (push) begin
			skid_q <= pipe_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q.y_out, out_q.x_out};
	assign m_tuser  = {out_q.y_rep, out_q.x_rep};

endmodule

### rtl/core/p2c_checker.sv
module p2c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a held result must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// input side only closes when a result is waiting behind a stalled one
	a_ready_low_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
		else $error("s_tready low without an output stall");

	// taking the stalled result moves the waiting one forward and reopens the input side
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !s_tready |=> s_tready && m_tvalid)
		else $error("skid item not moved forward");

endmodule

bind polar_to_cartesian_clamped p2c_checker u_p2c_checker (.*);

### tb/tb_polar_to_cartesian_clamped.sv
module tb_polar_to_cartesian_clamped;
	import p2c_pkg::*;

	localparam int     OUT_HOLD   = 300;   // long sink stall, fills the pipe
	localparam int     WATCHDOG   = 3000;
	localparam int     N_PHASES   = 8;
	localparam int     PHASE_LEN  = 166;
	localparam longint TURN_Q8    = 92160;  // 360 deg in Q16.8
	localparam longint GAIN_Q30   = 652032874;
	localparam longint HALF_LSB   = 64'sd35184372088832;  // 2^45
	localparam longint CORDIC_ATAN [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [39:0]         s_tdata;   // radius_in[15:0], angle_degrees[39:16]
	logic                m_tvalid;
	logic                m_tready;
	logic [39:0]         m_tdata;   // x_out[17:0], y_out[35:18], zero[39:36]
	logic [1:0]          m_tuser;   // x_replaced[0], y_replaced[1]
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [COORD_W-1:0]  cfg_data;

	bit no_gaps;
	bit hold_out;
	int n_sent;
	int idle_cycles;

	polar_to_cartesian_clamped uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	class coord_tracker;
		result_t                   coord_due_q[$];
		logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
		int                        errors;
		int                        checked;
		int                        x_hits;
		int                        y_hits;

		function new();
			x_lo = -18'sd131072;
			x_hi = 18'sd131071;
			y_lo = -18'sd131072;
			y_hi = 18'sd131071;
		endfunction

		function void set_limits(logic signed [COORD_W-1:0] xl, logic signed [COORD_W-1:0] xh,
				logic signed [COORD_W-1:0] yl, logic signed [COORD_W-1:0] yh);
			x_lo = xl;
			x_hi = xh;
			y_lo = yl;
			y_hi = yh;
		endfunction

		function int pending();
			return coord_due_q.size();
		endfunction

		function result_t rotate_and_window(logic signed [15:0] r, logic signed [23:0] ang);
			result_t res;
			longint  a, z, xa, ya, dx, dy, xg, yg;
			bit      flip;
			a = ang;
			a = a % TURN_Q8;
			if (a < 0)
				a += TURN_Q8;
			z = (a * 64'sd16777216) / 360;
			if (z >= 64'sd2147483648)
				z -= 64'sd4294967296;
			// fold into [-90, +90] deg, undo with a sign flip at the end
			flip = 1'b0;
			if (z > 64'sd1073741824) begin
				z -= 64'sd2147483648;
				flip = 1'b1;
			end else if (z < -64'sd1073741824) begin
				z += 64'sd2147483648;
				flip = 1'b1;
			end
			xa = r;
			xa = xa * 65536;
			ya = 0;
			for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
				dx = ya >>> i;
				dy = xa >>> i;
				if (z >= 0) begin
					xa -= dx;
					ya += dy;
					z  -= CORDIC_ATAN[i];
				end else begin
					xa += dx;
					ya -= dy;
					z  += CORDIC_ATAN[i];
				end
			end
			if (flip) begin
				xa = -xa;
				ya = -ya;
			end
			xg = (xa * GAIN_Q30 + HALF_LSB) >>> 46;
			yg = (ya * GAIN_Q30 + HALF_LSB) >>> 46;
			// out of window goes to the low limit, not saturated
			if (xg > x_hi || xg < x_lo) begin
				res.x_out = x_lo;
				res.x_rep = 1'b1;
			end else begin
				res.x_out = xg[COORD_W-1:0];
				res.x_rep = 1'b0;
			end
			if (yg > y_hi || yg < y_lo) begin
				res.y_out = y_lo;
				res.y_rep = 1'b1;
			end else begin
				res.y_out = yg[COORD_W-1:0];
				res.y_rep = 1'b0;
			end
			return res;
		endfunction

		function void note_polar(logic signed [15:0] r, logic signed [23:0] ang);
			coord_due_q.push_back(rotate_and_window(r, ang));
		endfunction

		function void check_coord(logic [39:0] data, logic [1:0] user);
			result_t want;
			if (coord_due_q.size() == 0) begin
				$display("%0t: unexpected item x=%0d y=%0d flags=%b", $time,
					$signed(data[17:0]), $signed(data[35:18]), user);
				errors++;
				return;
			end
			want = coord_due_q.pop_front();
			checked++;
			x_hits += want.x_rep;
			y_hits += want.y_rep;
			if (data[17:0] !== want.x_out) begin
				$display("%0t: x_out expected %0d actual %0d", $time,
					$signed(want.x_out), $signed(data[17:0]));
				errors++;
			end
			if (data[35:18] !== want.y_out) begin
				$display("%0t: y_out expected %0d actual %0d", $time,
					$signed(want.y_out), $signed(data[35:18]));
				errors++;
			end
			if (user[0] !== want.x_rep) begin
				$display("%0t: x_replaced expected %0b actual %0b", $time, want.x_rep, user[0]);
				errors++;
			end
			if (user[1] !== want.y_rep) begin
				$display("%0t: y_replaced expected %0b actual %0b", $time, want.y_rep, user[1]);
				errors++;
			end
			if (data[39:36] !== 4'd0) begin
				$display("%0t: tdata pad expected 0 actual %0h", $time, data[39:36]);
				errors++;
			end
		endfunction
	endclass

	coord_tracker tracker;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(15, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_limit();
		return COORD_W'($signed($urandom_range(0, 80000)) - 40000);
	endfunction

	task automatic send_polar(input logic signed [15:0] r, input logic signed [23:0] ang);
		int gap;
		gap = (no_gaps || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {ang, r};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tracker.note_polar(r, ang);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	task automatic set_window(input logic signed [COORD_W-1:0] xl,
			input logic signed [COORD_W-1:0] xh,
			input logic signed [COORD_W-1:0] yl,
			input logic signed [COORD_W-1:0] yh);
		cfg_we    <= 1'b1;
		cfg_index <= REG_X_LOW;
		cfg_data  <= xl;
		@(negedge clk);
		cfg_index <= REG_X_HIGH;
		cfg_data  <= xh;
		@(negedge clk);
		cfg_index <= REG_Y_LOW;
		cfg_data  <= yl;
		@(negedge clk);
		cfg_index <= REG_Y_HIGH;
		cfg_data  <= yh;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_limits(xl, xh, yl, yh);
	endtask

	// sink side
	initial begin
		int stall;
		m_tready <= 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out) begin
				m_tready <= 1'b0;
				repeat (OUT_HOLD) @(negedge clk);
				hold_out = 1'b0;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_coord(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t: no item moved for %0d cycles, %0d still due", $time,
				idle_cycles, tracker.pending());
			$display("FAIL polar_to_cartesian_clamped");
			$finish;
		end
	end

	initial begin
		int                 dir_r [20];
		int                 dir_a [20];
		logic signed [15:0] r;
		logic signed [23:0] ang;
		logic signed [17:0] lim_a, lim_b, lim_c, lim_d;
		int                 k90;
		dir_r = '{32767, -32768, 32767, 32767, 32767, -32768, 0, 1, -1, 32767,
			-32768, 256, 256, 12345, 12345, 32767, -32768, 32767, 0, -20000};
		// quadrant edges, fold edges, full turns and the angle field extremes
		dir_a = '{0, 0, 23040, 46080, 69120, 11520, 8388607, -8388608, 8388607, -8388608,
			8388607, 92160, -23040, 23041, 23039, 46081, -46080, 34560, 0, -69121};
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_X_LOW;
		cfg_data  <= '0;
		no_gaps   = 1'b1;
		hold_out  = 1'b0;
		n_sent    = 0;
		tracker   = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items under the reset windows
		for (int i = 0; i < 20; i++)
			send_polar(16'(dir_r[i]), 24'(dir_a[i]));

		for (int phase = 0; phase < N_PHASES; phase++) begin
			drain();
			lim_a = rand_limit();
			lim_b = rand_limit();
			lim_c = rand_limit();
			lim_d = rand_limit();
			case (phase)
				0: set_window(-18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071);
				2: set_window(18'sd5000, -18'sd5000,
					(lim_c < lim_d) ? lim_c : lim_d, (lim_c < lim_d) ? lim_d : lim_c);
				3: set_window(-18'sd1000, 18'sd1000, -18'sd20000, 18'sd5000);
				4: set_window(18'sd0, 18'sd0, 18'sd131071, 18'sd131071);
				5: set_window(-18'sd131072, -18'sd131072, 18'sd131071, -18'sd131072);
				7: set_window(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
				default: set_window((lim_a < lim_b) ? lim_a : lim_b, (lim_a < lim_b) ? lim_b : lim_a,
					(lim_c < lim_d) ? lim_c : lim_d, (lim_c < lim_d) ? lim_d : lim_c);
			endcase
			no_gaps = (phase == 0 || phase == 4);
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (phase == 1 && k == 40)
					hold_out = 1'b1;
				case ($urandom_range(0, 19))
					0, 1, 2: r = 16'($urandom_range(0, 600)) - 16'sd300;
					3:       r = 16'sd32767;
					4:       r = -16'sd32768;
					default: r = 16'($urandom);
				endcase
				if ($urandom_range(0, 4) < 2) begin
					// right around a multiple of 90 degrees
					k90 = $urandom_range(0, 728);
					ang = 24'((k90 - 364) * 23040 + $urandom_range(0, 6) - 3);
				end else begin
					ang = 24'($urandom);
				end
				send_polar(r, ang);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (tracker.pending() != 0)
			$display("%0t: %0d results never arrived", $time, tracker.pending());
		$display("%0d items sent, %0d results checked over %0d window settings",
			n_sent, tracker.checked, N_PHASES + 1);
		$display("x replaced %0d times, y replaced %0d times, one long sink stall",
			tracker.x_hits, tracker.y_hits);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("PASS polar_to_cartesian_clamped");
		end else begin
			$display("FAIL polar_to_cartesian_clamped");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/p2c_pkg.sv
rtl/core/p2c_angle.sv
rtl/core/p2c_cell.sv
rtl/core/p2c_gain.sv
rtl/core/polar_to_cartesian_clamped.sv
rtl/core/p2c_checker.sv
tb/tb_polar_to_cartesian_clamped.sv
